// File: design/lcv_pkg.sv
// shared types and constants of the learned checksum verifier
package lcv_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIENT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISC_ENABLE  = 2'd1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [10:0] CLIENT_COUNT_RESET = 11'd1024;

  // result codes
  typedef enum logic [2:0] {
    RS_STORED     = 3'd0,
    RS_LEARNING   = 3'd1,
    RS_MISMATCH   = 3'd2,
    RS_BAD_SLOT   = 3'd3,
    RS_BAD_CLIENT = 3'd4,
    RS_PASS       = 3'd5,
    RS_MISSING    = 3'd6
  } status_e;

  // item classes handed from front to back
  typedef enum logic [2:0] {
    K_ADD            = 3'd0,
    K_ADD_NOCLIENT   = 3'd1,
    K_BAD_SLOT       = 3'd2,
    K_CHECK          = 3'd3,
    K_CHECK_NOCLIENT = 3'd4
  } kind_e;

  typedef struct packed {
    logic        mode;
    logic [9:0]  client_index;
    logic [5:0]  func_index;
    logic [31:0] checksum_word;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [5:0]  missing_slot;
    logic        close_request;
    logic        all_settled;
  } out_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [9:0]  client;
    logic [5:0]  func;
    logic [31:0] word;
  } cmd_t;

endpackage

// File: design/lcv_fifo.sv
// small register queue used between the pipeline parts
module lcv_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T               mem_q [DEPTH];
  logic [AW-1:0]  wr_q, rd_q;
  logic [CW-1:0]  cnt_q;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: design/lcv_front.sv
// front end: classifies an incoming item into a command
module lcv_front import lcv_pkg::*; #(
  parameter int NUM_CLIENTS = 1024,
  parameter int NUM_FUNCS   = 32
) (
  input  in_item_t    item_i,
  input  logic [10:0] client_count_i,
  output cmd_t        cmd_o
);

  logic client_ok;
  logic slot_bad;

  assign client_ok = ({1'b0, item_i.client_index} < client_count_i) &&
                     (32'(item_i.client_index) < 32'(NUM_CLIENTS));
  assign slot_bad  = (7'(item_i.func_index) >= 7'(NUM_FUNCS));

  always_comb begin
    cmd_o.client = item_i.client_index;
    cmd_o.func   = item_i.func_index;
    cmd_o.word   = item_i.checksum_word;
    if (item_i.mode) begin
      cmd_o.kind = client_ok ? K_CHECK : K_CHECK_NOCLIENT;
    end else if (slot_bad) begin
      cmd_o.kind = K_BAD_SLOT;
    end else begin
      cmd_o.kind = client_ok ? K_ADD : K_ADD_NOCLIENT;
    end
  end

endmodule

// File: design/lcv_back.sv
// back end: client word memory, sample memory, vote and check scan
module lcv_back import lcv_pkg::*; #(
  parameter int NUM_CLIENTS = 1024,
  parameter int NUM_FUNCS   = 32,
  parameter int SAMPLES     = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  logic      cmd_empty_i,
  output logic      cmd_pop_o,
  input  logic      res_full_i,
  output logic      res_push_o,
  output out_item_t res_o,
  input  logic      disconnect_enable_i,
  output logic      clearing_o
);

  localparam int MAXN   = (NUM_FUNCS > SAMPLES) ? NUM_FUNCS : SAMPLES;
  localparam int IW     = (MAXN > 1) ? $clog2(MAXN) : 1;
  localparam int FW     = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
  localparam int SW     = $clog2(SAMPLES);
  localparam int CNW    = $clog2(SAMPLES + 1);
  localparam int SDEPTH = NUM_FUNCS * SAMPLES;
  localparam int SAW    = $clog2(SDEPTH);
  localparam int CDEPTH = NUM_CLIENTS * NUM_FUNCS;
  localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_EXEC  = 8'b0000_0100,
    S_VOTE  = 8'b0000_1000,
    S_VTAIL = 8'b0001_0000,
    S_SCAN  = 8'b0010_0000,
    S_STAIL = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e         state_q;
  cmd_t           cmd_q;
  out_item_t      res_q;
  logic [IW-1:0]  idx_q, rd_idx_q;
  logic [CNW-1:0] hits_q;
  logic           vld_q;
  logic [CAW-1:0] clr_q;

  // per-slot learning state
  logic [CNW-1:0]       cnt_q [NUM_FUNCS];
  logic [SW-1:0]        pos_q [NUM_FUNCS];
  logic [31:0]          s0_q  [NUM_FUNCS];
  logic [NUM_FUNCS-1:0] settled_q;
  logic                 all_q;

  // memories
  logic [31:0]    cw_mem [CDEPTH];
  logic [31:0]    ss_mem [SDEPTH];
  logic [31:0]    cw_rd_q, ss_rd_q;
  logic           cw_we, ss_we;
  logic [CAW-1:0] cw_addr;
  logic [SAW-1:0] ss_addr;
  logic [31:0]    cw_wd, ss_wd;

  logic [FW-1:0]  f_idx;
  logic [CNW-1:0] cur_cnt, cnt_inc, hits_nx;
  logic [SW-1:0]  cur_pos, pos_inc;
  logic [31:0]    cur_s0;
  logic           match, learn, is_add, vote_ok, scan_hit;
  logic [SAW-1:0] ss_base;
  logic [CAW-1:0] cw_base;
  logic [NUM_FUNCS-1:0] settled_nx;

  assign f_idx    = cmd_q.func[FW-1:0];
  assign cur_cnt  = cnt_q[f_idx];
  assign cur_pos  = pos_q[f_idx];
  assign cur_s0   = s0_q[f_idx];
  assign is_add   = (cmd_q.kind == K_ADD) || (cmd_q.kind == K_ADD_NOCLIENT);
  assign match    = (cur_s0 == cmd_q.word);
  assign learn    = is_add && !all_q && !settled_q[f_idx];
  assign cnt_inc  = (cur_cnt == CNW'(SAMPLES)) ? cur_cnt : cur_cnt + 1'b1;
  assign pos_inc  = (cur_pos == SW'(SAMPLES - 1)) ? '0 : cur_pos + 1'b1;
  assign ss_base  = SAW'(f_idx) * SAW'(SAMPLES);
  assign cw_base  = CAW'(cmd_q.client) * CAW'(NUM_FUNCS);
  assign hits_nx  = hits_q + CNW'(vld_q && (ss_rd_q == cur_s0));
  assign vote_ok  = ({1'b0, hits_nx} + 1'b1) >= (CNW + 1)'(SAMPLES);
  assign scan_hit = vld_q && (res_q.status == RS_PASS) && (cw_rd_q == '0);
  assign settled_nx = settled_q | (NUM_FUNCS'(1) << f_idx);

  assign cmd_pop_o  = (state_q == S_IDLE) && !cmd_empty_i;
  assign res_push_o = (state_q == S_DONE);
  assign clearing_o = (state_q == S_CLEAR);

  always_comb begin
    res_o             = res_q;
    res_o.all_settled = all_q;
  end

  // memory port selection
  always_comb begin
    cw_we   = 1'b0;
    cw_addr = clr_q;
    cw_wd   = '0;
    ss_we   = 1'b0;
    ss_addr = ss_base + SAW'(idx_q);
    ss_wd   = cmd_q.word;
    case (state_q)
      S_CLEAR: begin
        cw_we = 1'b1;
      end
      S_EXEC: begin
        cw_addr = cw_base + CAW'(f_idx);
        cw_wd   = cmd_q.word;
        cw_we   = (cmd_q.kind == K_ADD) && (!all_q || match);
        if (learn) begin
          ss_we   = 1'b1;
          ss_addr = ss_base + SAW'(cur_pos);
        end
      end
      S_SCAN: begin
        cw_we   = 1'b1;
        cw_addr = cw_base + CAW'(idx_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cw_we) begin
      cw_mem[cw_addr] <= cw_wd;
    end
    cw_rd_q <= cw_mem[cw_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ss_we) begin
      ss_mem[ss_addr] <= ss_wd;
    end
    ss_rd_q <= ss_mem[ss_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      cmd_q     <= '0;
      res_q     <= '0;
      idx_q     <= '0;
      rd_idx_q  <= '0;
      hits_q    <= '0;
      vld_q     <= 1'b0;
      clr_q     <= '0;
      settled_q <= '0;
      all_q     <= 1'b0;
      for (int i = 0; i < NUM_FUNCS; i++) begin
        cnt_q[i] <= '0;
        pos_q[i] <= '0;
        s0_q[i]  <= '0;
      end
    end else begin
      vld_q    <= (state_q == S_VOTE) || (state_q == S_SCAN);
      rd_idx_q <= idx_q;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == CAW'(CDEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!cmd_empty_i) begin
            cmd_q   <= cmd_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_q.missing_slot  <= '0;
          res_q.close_request <= 1'b0;
          idx_q               <= '0;
          hits_q              <= '0;
          state_q             <= S_DONE;
          case (cmd_q.kind)
            K_BAD_SLOT: begin
              res_q.status <= RS_BAD_SLOT;
            end
            K_CHECK_NOCLIENT: begin
              res_q.status <= RS_BAD_CLIENT;
            end
            K_CHECK: begin
              res_q.status <= RS_PASS;
              state_q      <= S_SCAN;
            end
            default: begin
              if (cmd_q.kind == K_ADD_NOCLIENT) begin
                res_q.status <= RS_BAD_CLIENT;
              end else if (!all_q) begin
                res_q.status <= RS_LEARNING;
              end else if (match) begin
                res_q.status <= RS_STORED;
              end else begin
                res_q.status        <= RS_MISMATCH;
                res_q.close_request <= disconnect_enable_i;
              end
              if (learn) begin
                pos_q[f_idx] <= pos_inc;
                cnt_q[f_idx] <= cnt_inc;
                if (cur_pos == '0) begin
                  s0_q[f_idx] <= cmd_q.word;
                end
                if (cnt_inc == CNW'(SAMPLES)) begin
                  state_q <= S_VOTE;
                end
              end
            end
          endcase
        end
        S_VOTE: begin
          hits_q <= hits_nx;
          idx_q  <= idx_q + 1'b1;
          if (idx_q == IW'(SAMPLES - 1)) begin
            state_q <= S_VTAIL;
          end
        end
        S_VTAIL: begin
          if (vote_ok) begin
            settled_q <= settled_nx;
            all_q     <= &settled_nx;
          end
          state_q <= S_DONE;
        end
        S_SCAN: begin
          idx_q <= idx_q + 1'b1;
          if (scan_hit) begin
            res_q.status        <= RS_MISSING;
            res_q.missing_slot  <= 6'(rd_idx_q);
            res_q.close_request <= disconnect_enable_i;
          end
          if (idx_q == IW'(NUM_FUNCS - 1)) begin
            state_q <= S_STAIL;
          end
        end
        S_STAIL: begin
          if (scan_hit) begin
            res_q.status        <= RS_MISSING;
            res_q.missing_slot  <= 6'(rd_idx_q);
            res_q.close_request <= disconnect_enable_i;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!res_full_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_all_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    all_q |=> all_q) else $error("all_settled dropped");

  a_all_implies_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    all_q |-> (&settled_q)) else $error("all_settled with an open slot");

  a_no_pop_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> (!cmd_pop_o && !res_push_o))
    else $error("command taken during clear pass");

  a_vote_follows_learn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_VOTE) && $past(state_q == S_EXEC) |-> $past(learn))
    else $error("vote without a new sample");

endmodule

// File: design/learned_checksum_verifier.sv
// top level of the learned checksum verifier
//
//   channel   direction  handshake                transfer when
//   item      in         push / full              push && !full
//   result    out        empty / pop              pop && !empty
//   config    in         cfg_valid_i/cfg_ready_o  cfg_valid_i && cfg_ready_o
//
// add item: EXEC then DONE, with VOTE and VTAIL between when a slot can vote
// check item: reads the NUM_FUNCS words in turn on the client memory's single port
// after reset the client memory is swept to zero, all NUM_CLIENTS * NUM_FUNCS
// words, during which full stays high; config writes are taken at any time
// the front queue takes items while the back works; the result queue lets
// the back finish while the consumer stalls
module learned_checksum_verifier import lcv_pkg::*; #(
  parameter int NUM_CLIENTS = 1024,
  parameter int NUM_FUNCS   = 32,
  parameter int SAMPLES     = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // item side
  input  logic                  push,
  output logic                  full,
  input  in_item_t              item_i,
  // result side
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             result_o,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [10:0] client_count_q;
  logic        disc_en_q;

  cmd_t      front_cmd, back_cmd;
  logic      cmd_full, cmd_empty, cmd_pop;
  logic      res_full, res_push;
  out_item_t back_res;
  logic      clearing;

  // config registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      client_count_q <= CLIENT_COUNT_RESET;
      disc_en_q      <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CLIENT_COUNT: client_count_q <= cfg_data_i[10:0];
        REG_DISC_ENABLE:  disc_en_q      <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // no items while the client memory is being cleared
  assign full = cmd_full || clearing;

  // front: classify
  lcv_front #(
    .NUM_CLIENTS (NUM_CLIENTS),
    .NUM_FUNCS   (NUM_FUNCS)
  ) u_front (
    .item_i         (item_i),
    .client_count_i (client_count_q),
    .cmd_o          (front_cmd)
  );

  // command queue decouples front from back
  lcv_fifo #(
    .T     (cmd_t),
    .DEPTH (2)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && !clearing),
    .data_i  (front_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (back_cmd),
    .empty_o (cmd_empty)
  );

  // back: memories, learning and scan
  lcv_back #(
    .NUM_CLIENTS (NUM_CLIENTS),
    .NUM_FUNCS   (NUM_FUNCS),
    .SAMPLES     (SAMPLES)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (back_cmd),
    .cmd_empty_i         (cmd_empty),
    .cmd_pop_o           (cmd_pop),
    .res_full_i          (res_full),
    .res_push_o          (res_push),
    .res_o               (back_res),
    .disconnect_enable_i (disc_en_q),
    .clearing_o          (clearing)
  );

  // result queue toward the consumer
  lcv_fifo #(
    .T     (out_item_t),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (result_o),
    .empty_o (empty)
  );

endmodule

// File: tb/tb.sv
// testbench of the learned checksum verifier: table-driven and random items against a predictor
module tb;
  import lcv_pkg::*;

  localparam int NCLI   = 1024;
  localparam int NFUNC  = 32;
  localparam int NSAMP  = 8;
  localparam int N_RAND = 800;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  in_item_t              item_i = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  out_item_t             result_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  learned_checksum_verifier dut (.*);

  always #6 clk_i = ~clk_i;

  // predictor state
  logic [31:0] words_q [NCLI*NFUNC];
  logic [31:0] samp_q [NFUNC*NSAMP];
  int unsigned samp_cnt [NFUNC];
  int unsigned samp_pos [NFUNC];
  bit          slot_done [NFUNC];
  logic [31:0] ref_word [NFUNC];
  bit          all_done;
  int unsigned cli_limit;
  bit          disc_en;

  out_item_t   pending_res [$];
  // typed-in expectation for directed rows; status RS_* with flag typed_use
  out_item_t   typed_res [$];
  bit          typed_use [$];
  int          n_fail;
  int          n_mism;
  bit          drive_done;

  function automatic bit cli_ok(logic [9:0] c);
    return c < cli_limit && c < NCLI;
  endfunction

  function automatic void learn_slot(int f, logic [31:0] w);
    int hits;
    samp_q[f*NSAMP + samp_pos[f]] = w;
    samp_pos[f] = (samp_pos[f] + 1) % NSAMP;
    if (samp_cnt[f] < NSAMP) samp_cnt[f]++;
    if (samp_cnt[f] >= NSAMP) begin
      hits = 0;
      for (int i = 0; i < NSAMP; i++)
        if (samp_q[f*NSAMP+i] == samp_q[f*NSAMP]) hits++;
      if (hits + 1 >= NSAMP) begin
        slot_done[f] = 1'b1;
        all_done = 1'b1;
        for (int i = 0; i < NFUNC; i++) begin
          if (!slot_done[i]) all_done = 1'b0;
          ref_word[i] = samp_q[i*NSAMP];
        end
      end
    end
  endfunction

  function automatic out_item_t predict_verdict(in_item_t it);
    out_item_t r;
    int c, f;
    r = '0;
    c = it.client_index;
    f = it.func_index;
    if (it.mode) begin
      if (!cli_ok(it.client_index)) r.status = RS_BAD_CLIENT;
      else begin
        r.status = RS_PASS;
        for (int i = 0; i < NFUNC; i++)
          if (words_q[c*NFUNC+i] == 0) begin
            r.status = RS_MISSING;
            r.missing_slot = 6'(i);
            r.close_request = disc_en;
            break;
          end
        for (int i = 0; i < NFUNC; i++) words_q[c*NFUNC+i] = '0;
      end
    end else if (f >= NFUNC) begin
      r.status = RS_BAD_SLOT;
    end else begin
      if (!cli_ok(it.client_index)) r.status = RS_BAD_CLIENT;
      else if (!all_done) begin
        words_q[c*NFUNC+f] = it.checksum_word;
        r.status = RS_LEARNING;
      end else if (ref_word[f] == it.checksum_word) begin
        words_q[c*NFUNC+f] = it.checksum_word;
        r.status = RS_STORED;
      end else begin
        r.status = RS_MISMATCH;
        r.close_request = disc_en;
      end
      if (!all_done && !slot_done[f]) learn_slot(f, it.checksum_word);
    end
    r.all_settled = all_done;
    return r;
  endfunction

  // one item transfer; exp_ok marks a typed-in expectation
  task automatic send_item(in_item_t it, bit exp_ok, out_item_t exp_r);
    out_item_t p;
    @(negedge clk_i);
    item_i <= it;
    push   <= 1'b1;
    do @(posedge clk_i); while (full);
    p = predict_verdict(it);
    pending_res.push_back(p);
    typed_use.push_back(exp_ok);
    typed_res.push_back(exp_r);
    @(negedge clk_i);
    push <= 1'b0;
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_CLIENT_COUNT) cli_limit = val & 32'h7ff;
    else if (idx == REG_DISC_ENABLE) disc_en = val[0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // idle point: all results back, then the block's add/vote latency
  task automatic drain;
    while (pending_res.size() != 0) @(negedge clk_i);
    repeat (NFUNC + 2*NSAMP + 10) @(negedge clk_i);
  endtask

  function automatic in_item_t mk(bit m, int c, int f, logic [31:0] w);
    in_item_t it;
    it.mode = m;
    it.client_index = 10'(c);
    it.func_index = 6'(f);
    it.checksum_word = w;
    return it;
  endfunction

  function automatic out_item_t mkr(status_e s, int ms, bit cl, bit st);
    out_item_t r;
    r.status = s;
    r.missing_slot = 6'(ms);
    r.close_request = cl;
    r.all_settled = st;
    return r;
  endfunction

  // burst-and-gap sender on top of send_item
  int unsigned burst_left;
  task automatic pace;
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 20)) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
  endtask

  // learning phase traffic: mostly the slot's agreed word, some noise
  logic [31:0] good_word [NFUNC];

  task automatic random_phase(int n, int clients, int settle_pct);
    in_item_t it;
    int f;
    for (int k = 0; k < n; k++) begin
      pace();
      f = $urandom_range(0, NFUNC-1);
      it = mk(0, $urandom_range(0, clients-1), f, good_word[f]);
      case ($urandom_range(0, 99)) inside
        [0:9]:   it.mode = 1'b1;
        [10:13]: it.func_index = 6'($urandom_range(NFUNC, 63));
        [14:17]: it.client_index = 10'($urandom);
        [18:27]: it.checksum_word = $urandom;
        default: if ($urandom_range(0, 99) >= settle_pct) it.checksum_word = $urandom;
      endcase
      if ($urandom_range(0, 30) == 0) it.checksum_word = {32{1'b1}} ^ $urandom_range(0, 1);
      send_item(it, 1'b0, '0);
    end
  endtask

  // result side: own stall pattern, compare against oldest expectation
  logic [7:0] stall_pat;
  always @(negedge clk_i) begin
    stall_pat <= {stall_pat[6:0], stall_pat[7] ^ stall_pat[5] ^ ($urandom_range(0, 9) == 0)};
    pop <= ($urandom_range(0, 99) < 60) ? 1'b1 : ~stall_pat[0];
  end

  always @(posedge clk_i) begin
    out_item_t exp_r, typed;
    bit has_typed;
    if (rst_ni && pop && !empty) begin
      if (pending_res.size() == 0) begin
        n_fail++;
        if (n_mism++ < 10) $display("unexpected result %p", result_o);
      end else begin
        exp_r = pending_res.pop_front();
        typed = typed_res.pop_front();
        has_typed = typed_use.pop_front();
        if (has_typed && typed != exp_r) begin
          n_fail++;
          if (n_mism++ < 10) $display("table row %p disagrees with predictor %p", typed, exp_r);
        end
        if (result_o.status !== exp_r.status || result_o.missing_slot !== exp_r.missing_slot ||
            result_o.close_request !== exp_r.close_request ||
            result_o.all_settled !== exp_r.all_settled) begin
          n_fail++;
          if (n_mism++ < 10) $display("result mismatch: expected %p actual %p", exp_r, result_o);
        end
      end
    end
  end

  // directed table
  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t res;
  } row_t;
  row_t rows [$];

  initial begin
    for (int i = 0; i < NCLI*NFUNC; i++) words_q[i] = '0;
    for (int i = 0; i < NFUNC*NSAMP; i++) samp_q[i] = '0;
    for (int i = 0; i < NFUNC; i++) begin
      samp_cnt[i] = 0; samp_pos[i] = 0; slot_done[i] = 0; ref_word[i] = '0;
      good_word[i] = $urandom;
    end
    all_done = 0;
    cli_limit = CLIENT_COUNT_RESET;
    disc_en = 0;
    n_fail = 0;
    n_mism = 0;
    burst_left = 0;
    stall_pat = 8'h5a;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // after reset: empty client, bad slot, learning, extremes
    rows.push_back('{mk(1, 0, 0, 0), 1, mkr(RS_MISSING, 0, 0, 0)});
    rows.push_back('{mk(1, 1023, 63, '1), 1, mkr(RS_MISSING, 0, 0, 0)});
    rows.push_back('{mk(0, 5, 32, 1), 1, mkr(RS_BAD_SLOT, 0, 0, 0)});
    rows.push_back('{mk(0, 1023, 63, '1), 1, mkr(RS_BAD_SLOT, 0, 0, 0)});
    rows.push_back('{mk(0, 0, 0, '1), 1, mkr(RS_LEARNING, 0, 0, 0)});
    rows.push_back('{mk(0, 1023, 31, 0), 1, mkr(RS_LEARNING, 0, 0, 0)});
    rows.push_back('{mk(0, 1023, 31, 32'h1234), 0, '0});
    rows.push_back('{mk(1, 1023, 0, 0), 0, '0});
    for (int i = 0; i < rows.size(); i++) begin
      @(negedge clk_i);
      send_item(rows[i].it, rows[i].typed, rows[i].res);
    end
    drain();

    // small client count, close enabled: bad client in both modes, missing with close
    write_cfg(REG_CLIENT_COUNT, 1);
    write_cfg(REG_DISC_ENABLE, 1);
    rows.delete();
    rows.push_back('{mk(0, 1, 3, 7), 1, mkr(RS_BAD_CLIENT, 0, 0, 0)});
    rows.push_back('{mk(1, 1, 0, 0), 1, mkr(RS_BAD_CLIENT, 0, 0, 0)});
    rows.push_back('{mk(0, 0, 0, 9), 0, '0});
    rows.push_back('{mk(1, 0, 0, 0), 0, '0});
    for (int i = 0; i < rows.size(); i++) begin
      @(negedge clk_i);
      send_item(rows[i].it, rows[i].typed, rows[i].res);
    end
    // a client filled in every slot then checked: pass
    for (int f = 0; f < NFUNC; f++) send_item(mk(0, 0, f, good_word[f] | 1), 0, '0);
    send_item(mk(1, 0, 0, 0), 0, '0);
    drain();

    // random learning, several settings, then compare phase
    write_cfg(REG_CLIENT_COUNT, 8);
    write_cfg(REG_DISC_ENABLE, 0);
    random_phase(N_RAND/4, 16, 85);
    drain();
    write_cfg(REG_CLIENT_COUNT, 1024);
    write_cfg(REG_DISC_ENABLE, 1);
    random_phase(N_RAND/4, 1024, 90);
    drain();
    // make sure every slot settles before the compare phase
    for (int f = 0; f < NFUNC; f++)
      repeat (NSAMP) send_item(mk(0, $urandom_range(0, 3), f, good_word[f]), 0, '0);
    drain();
    write_cfg(REG_CLIENT_COUNT, 4);
    random_phase(N_RAND/4, 6, 80);
    drain();
    write_cfg(REG_CLIENT_COUNT, 2047);
    write_cfg(REG_DISC_ENABLE, 0);
    random_phase(N_RAND/4, 1024, 70);

    drain();
    if (n_fail == 0)
      $display("learned_checksum_verifier verification clean");
    else
      $display("learned_checksum_verifier verification failed");
    $finish;
  end

  // run limit: reset sweep plus slow items several times over
  initial begin
    #(12 * 5000000);
    $display("learned_checksum_verifier verification failed");
    $finish;
  end
endmodule
